// File: hdl/uvs_pkg.sv
// ============================================================================
// UV sphere mesh generator package
// Shared beat types, state codes, fixed-point constants and rounding helpers.
// ============================================================================
package uvs_pkg;

    typedef struct packed {
        logic [7:0] stack_index;
        logic [7:0] sector_index;
    } req_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [15:0]        corner_a;
        logic [15:0]        corner_b;
        logic [15:0]        corner_c;
        logic               last;
    } rsp_t;

    typedef enum logic [1:0] {
        CFG_RADIUS  = 2'd0,
        CFG_STACKS  = 2'd1,
        CFG_SECTORS = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        BEAT_VERT,
        BEAT_UPPER,
        BEAT_LOWER
    } beat_t;

    typedef enum logic [1:0] {
        DIV_SECTOR,
        DIV_STACK,
        DIV_DONE
    } div_state_t;

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    localparam int HORNER_STEPS = 7;
    localparam int SC_LAT       = 3 * HORNER_STEPS + 4;

    function automatic logic [30:0] horner_step(input logic [31:0] y,
                                                input logic [31:0] qe,
                                                input logic [7:0]  d);
        logic [39:0] prod;
        logic [31:0] rem;
        logic [31:0] q;
        prod = 40'(qe) * 40'(d);
        rem  = y - prod[31:0];
        q    = (rem >= 32'(d)) ? qe + 32'd1 : qe;
        if (q > 32'(ONE_Q30)) begin
            return '0;
        end
        return 31'(32'(ONE_Q30) - q);
    endfunction

    function automatic logic signed [63:0] round_q30(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        r   = (mag + 64'h2000_0000) >> 30;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] round_q15(input logic signed [31:0] v);
        logic [31:0] mag;
        logic [31:0] r;
        mag = v[31] ? 32'(-v) : 32'(v);
        r   = (mag + 32'h0000_4000) >> 15;
        return v[31] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh0000_0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        if (v > 32'sh0000_7FFF) begin
            return 16'sh7FFF;
        end
        if (v < -32'sh0000_8000) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

// File: hdl/uv_sphere_mesh_generator.sv
// ============================================================================
// UV sphere mesh generator
// For each grid point gives its vertex position and normal, then the
// triangles of the grid cell at that point.
// ============================================================================
//  channel   direction  handshake              beat
//  req       in         req_valid/req_ready    req_t: stack and sector index
//  rsp       out        rsp_valid/rsp_ready    rsp_t: one vertex or triangle
//  cfg       in         cfg_write              cfg_index, cfg_data
//
// A grid point can enter every cycle while the output register is free or its last beat
// is being taken, and leaves as one to three beats. It holds the output register until
// its last beat is taken, so no new grid point enters while beats are still to go.
// After reset and after each write of a count, the reciprocal unit runs
// with req_ready low.
// A stall on rsp freezes the whole pipeline.
// ============================================================================
module uv_sphere_mesh_generator
    import uvs_pkg::*;
#(
    parameter int MAX_COUNT = 255,
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req_data,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp_data,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CW    = $clog2(MAX_COUNT + 1);
    localparam int XW    = 8 + CW;
    localparam int KR    = XW + 1;
    localparam int PW    = XW + KR;
    localparam int NSIDE = SC_LAT + 8;

    typedef struct packed {
        logic [15:0] k1;
        logic [15:0] k1p;
        logic [15:0] k2;
        logic [15:0] k2p;
        logic        has_cell;
        logic        up;
        logic        dn;
    } side_t;

    logic [31:0] radius_reg;
    logic [7:0]  stack_count_reg;
    logic [7:0]  sector_count_reg;
    logic [CW-1:0] stacks_c;
    logic [CW-1:0] sectors_c;

    div_state_t  div_state_reg, div_state_next;
    logic [5:0]  div_cnt_reg, div_cnt_next;
    logic [CW-1:0] div_rem_reg, div_rem_next;
    logic [31:0] div_quo_reg, div_quo_next;
    logic [31:0] q_s_reg, q_s_next, q_t_reg, q_t_next;
    logic [CW-1:0] r_s_reg, r_s_next, r_t_reg, r_t_next;
    logic [CW-1:0] div_d;
    logic [CW:0]   rem_sh, rem_new;
    logic          fits;
    logic [KR-1:0] m_s, m_t;

    logic        adv;
    logic        v1_reg;
    logic [7:0]  i1_reg, j1_reg, i_cl, j_cl;
    side_t       side_c;
    logic [31:0] k1_full;
    side_t       side_reg [0:NSIDE-1];
    logic        vld_reg  [0:NSIDE-1];

    logic [31:0] iq2_reg, jq2_reg, iq3_reg, jq3_reg, iq4_reg, jq4_reg;
    logic [XW-1:0] ix2_reg, jx2_reg, ix3_reg, jx3_reg;
    logic [7:0]  ie3_reg, je3_reg, ti4_reg, tj4_reg, ti_c, tj_c;
    logic [XW-1:0] ri_c, rj_c;
    logic [31:0] ph_i_reg, ph_j_reg;

    logic signed [31:0] ss, cs, sg, cg;
    logic signed [31:0] nx1_reg;
    logic signed [63:0] py1_reg, pz1_reg;
    logic signed [31:0] n2_reg [0:2];
    logic signed [63:0] pp3_reg [0:2];
    logic signed [15:0] nm3_reg [0:2];
    logic signed [31:0] pos4_reg [0:2];
    logic signed [15:0] nm4_reg [0:2];

    logic               o_valid_reg, o_valid_next;
    beat_t              beat_reg, beat_next;
    logic signed [31:0] h_pos_reg [0:2];
    logic signed [15:0] h_nm_reg  [0:2];
    side_t              h_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg       <= 32'd1 << FRAC_BITS;
            stack_count_reg  <= 8'd16;
            sector_count_reg <= 8'd32;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RADIUS:  radius_reg       <= cfg_data;
                CFG_STACKS:  stack_count_reg  <= cfg_data[7:0];
                CFG_SECTORS: sector_count_reg <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        if (stack_count_reg < 8'd2)
            stacks_c = CW'(2);
        else if (32'(stack_count_reg) > MAX_COUNT)
            stacks_c = CW'(MAX_COUNT);
        else
            stacks_c = CW'(stack_count_reg);
        if (sector_count_reg < 8'd3)
            sectors_c = CW'(3);
        else if (32'(sector_count_reg) > MAX_COUNT)
            sectors_c = CW'(MAX_COUNT);
        else
            sectors_c = CW'(sector_count_reg);
    end

    // Reciprocal unit: floor(2^32 / sectors) and floor(2^31 / stacks) with remainders.
    always_comb
    begin
        div_d   = (div_state_reg == DIV_STACK) ? stacks_c : sectors_c;
        rem_sh  = {div_rem_reg,
                   div_cnt_reg == ((div_state_reg == DIV_STACK) ? 6'd31 : 6'd32)};
        fits    = rem_sh >= {1'b0, div_d};
        rem_new = fits ? rem_sh - {1'b0, div_d} : rem_sh;

        div_state_next = div_state_reg;
        div_cnt_next   = div_cnt_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        q_s_next       = q_s_reg;
        r_s_next       = r_s_reg;
        q_t_next       = q_t_reg;
        r_t_next       = r_t_reg;

        case (div_state_reg)
            DIV_SECTOR, DIV_STACK:
            begin
                div_rem_next = rem_new[CW-1:0];
                div_quo_next = {div_quo_reg[30:0], fits};
                div_cnt_next = div_cnt_reg - 6'd1;
                if (div_cnt_reg == 6'd0)
                begin
                    div_rem_next = '0;
                    div_quo_next = '0;
                    if (div_state_reg == DIV_SECTOR)
                    begin
                        q_s_next       = {div_quo_reg[30:0], fits};
                        r_s_next       = rem_new[CW-1:0];
                        div_state_next = DIV_STACK;
                        div_cnt_next   = 6'd31;
                    end
                    else
                    begin
                        q_t_next       = {div_quo_reg[30:0], fits};
                        r_t_next       = rem_new[CW-1:0];
                        div_state_next = DIV_DONE;
                    end
                end
            end
            DIV_DONE:
            begin
                div_state_next = DIV_DONE;
            end
            default:
            begin
                div_state_next = DIV_DONE;
            end
        endcase

        if (cfg_write && (cfg_index == CFG_STACKS || cfg_index == CFG_SECTORS))
        begin
            div_state_next = DIV_SECTOR;
            div_cnt_next   = 6'd32;
            div_rem_next   = '0;
            div_quo_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_state_reg <= DIV_SECTOR;
            div_cnt_reg   <= 6'd32;
            div_rem_reg   <= '0;
            div_quo_reg   <= '0;
        end
        else
        begin
            div_state_reg <= div_state_next;
            div_cnt_reg   <= div_cnt_next;
            div_rem_reg   <= div_rem_next;
            div_quo_reg   <= div_quo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_s_reg <= q_s_next;
        r_s_reg <= r_s_next;
        q_t_reg <= q_t_next;
        r_t_reg <= r_t_next;
    end

    assign m_s = q_s_reg[31:32-KR];
    assign m_t = q_t_reg[30:31-KR];

    assign adv       = !o_valid_reg || (rsp_ready && rsp_data.last);
    assign req_ready = adv && (div_state_reg == DIV_DONE);

    always_comb
    begin
        i_cl = (32'(req_data.stack_index) > 32'(stacks_c)) ? 8'(stacks_c)
                                                           : req_data.stack_index;
        j_cl = (32'(req_data.sector_index) > 32'(sectors_c)) ? 8'(sectors_c)
                                                             : req_data.sector_index;
    end

    always_comb
    begin
        k1_full         = 32'(i1_reg) * (32'(sectors_c) + 32'd1) + 32'(j1_reg);
        side_c.k1       = k1_full[15:0];
        side_c.k1p      = k1_full[15:0] + 16'd1;
        side_c.k2       = 16'(k1_full + 32'(sectors_c) + 32'd1);
        side_c.k2p      = 16'(k1_full + 32'(sectors_c) + 32'd2);
        side_c.has_cell = (32'(i1_reg) < 32'(stacks_c)) && (32'(j1_reg) < 32'(sectors_c));
        side_c.up       = i1_reg != 8'd0;
        side_c.dn       = 32'(i1_reg) != 32'(stacks_c) - 32'd1;
    end

    always_comb
    begin
        ri_c = ix3_reg - XW'(XW'(ie3_reg) * XW'(stacks_c));
        rj_c = jx3_reg - XW'(XW'(je3_reg) * XW'(sectors_c));
        ti_c = (ri_c >= XW'(stacks_c)) ? ie3_reg + 8'd1 : ie3_reg;
        tj_c = (rj_c >= XW'(sectors_c)) ? je3_reg + 8'd1 : je3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            for (int n = 0; n < NSIDE; n++)
            begin
                vld_reg[n] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg     <= req_valid && req_ready;
            vld_reg[0] <= v1_reg;
            for (int n = 1; n < NSIDE; n++)
            begin
                vld_reg[n] <= vld_reg[n-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i1_reg <= i_cl;
            j1_reg <= j_cl;

            iq2_reg <= 32'(40'(i1_reg) * 40'(q_t_reg));
            jq2_reg <= 32'(40'(j1_reg) * 40'(q_s_reg));
            ix2_reg <= XW'(XW'(i1_reg) * XW'(r_t_reg));
            jx2_reg <= XW'(XW'(j1_reg) * XW'(r_s_reg));
            side_reg[0] <= side_c;
            for (int n = 1; n < NSIDE; n++)
            begin
                side_reg[n] <= side_reg[n-1];
            end

            ie3_reg <= 8'((PW'(ix2_reg) * PW'(m_t)) >> KR);
            je3_reg <= 8'((PW'(jx2_reg) * PW'(m_s)) >> KR);
            iq3_reg <= iq2_reg;
            jq3_reg <= jq2_reg;
            ix3_reg <= ix2_reg;
            jx3_reg <= jx2_reg;

            ti4_reg <= ti_c;
            tj4_reg <= tj_c;
            iq4_reg <= iq3_reg;
            jq4_reg <= jq3_reg;

            ph_i_reg <= 32'h4000_0000 - (iq4_reg + 32'(ti4_reg));
            ph_j_reg <= jq4_reg + 32'(tj4_reg);

            nx1_reg <= ss;
            py1_reg <= 64'(cs) * 64'(sg);
            pz1_reg <= 64'(cs) * 64'(cg);

            n2_reg[0] <= nx1_reg;
            n2_reg[1] <= 32'(round_q30(py1_reg));
            n2_reg[2] <= 32'(round_q30(pz1_reg));

            for (int f = 0; f < 3; f++)
            begin
                pp3_reg[f]  <= $signed({32'd0, radius_reg}) * 64'(n2_reg[f]);
                nm3_reg[f]  <= sat16(round_q15(n2_reg[f]));
                pos4_reg[f] <= sat32(round_q30(pp3_reg[f]));
                nm4_reg[f]  <= nm3_reg[f];
                h_pos_reg[f] <= pos4_reg[f];
                h_nm_reg[f]  <= nm4_reg[f];
            end
            h_side_reg <= side_reg[NSIDE-1];
        end
    end

    uvs_sincos u_stack_trig (
        .clk     (clk),
        .en      (adv),
        .phase   (ph_i_reg),
        .sin_q30 (ss),
        .cos_q30 (cs)
    );

    uvs_sincos u_sector_trig (
        .clk     (clk),
        .en      (adv),
        .phase   (ph_j_reg),
        .sin_q30 (sg),
        .cos_q30 (cg)
    );

    always_comb
    begin
        rsp_data = '0;
        case (beat_reg)
            BEAT_VERT:
            begin
                rsp_data.kind   = KIND_VERTEX;
                rsp_data.pos_x  = h_pos_reg[0];
                rsp_data.pos_y  = h_pos_reg[1];
                rsp_data.pos_z  = h_pos_reg[2];
                rsp_data.norm_x = h_nm_reg[0];
                rsp_data.norm_y = h_nm_reg[1];
                rsp_data.norm_z = h_nm_reg[2];
                rsp_data.last   = !(h_side_reg.has_cell && (h_side_reg.up || h_side_reg.dn));
            end
            BEAT_UPPER:
            begin
                rsp_data.kind     = KIND_TRIANGLE;
                rsp_data.corner_a = h_side_reg.k1;
                rsp_data.corner_b = h_side_reg.k2;
                rsp_data.corner_c = h_side_reg.k1p;
                rsp_data.last     = !h_side_reg.dn;
            end
            BEAT_LOWER:
            begin
                rsp_data.kind     = KIND_TRIANGLE;
                rsp_data.corner_a = h_side_reg.k1p;
                rsp_data.corner_b = h_side_reg.k2;
                rsp_data.corner_c = h_side_reg.k2p;
                rsp_data.last     = 1'b1;
            end
            default:
            begin
                rsp_data.last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        beat_next    = beat_reg;
        o_valid_next = o_valid_reg;
        if (adv)
        begin
            beat_next    = BEAT_VERT;
            o_valid_next = vld_reg[NSIDE-1];
        end
        else if (rsp_ready)
        begin
            case (beat_reg)
                BEAT_VERT:  beat_next = h_side_reg.up ? BEAT_UPPER : BEAT_LOWER;
                BEAT_UPPER: beat_next = BEAT_LOWER;
                default:    beat_next = BEAT_VERT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            beat_reg    <= BEAT_VERT;
        end
        else
        begin
            o_valid_reg <= o_valid_next;
            beat_reg    <= beat_next;
        end
    end

    assign rsp_valid = o_valid_reg;

    a_no_req_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> div_state_reg == DIV_DONE)
        else $error("Request taken while the reciprocal unit is running.");

    a_cell_beats_follow: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp_data.last |=> rsp_valid && rsp_data.kind)
        else $error("A triangle beat did not follow a beat that was not last.");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && rsp_data.last |=> beat_reg == BEAT_VERT)
        else $error("The beat after a last beat is not a vertex.");

    a_stall_holds_beat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(beat_reg) && rsp_valid)
        else $error("The beat moved on while the output was stalled.");

endmodule

// File: hdl/uvs_sincos.sv
// ============================================================================
// UV sphere sine and cosine pipeline
// Turns a 32-bit phase into Q2.30 sine and cosine through pipelined
// Horner-form Taylor series, one register stage per multiply.
// ============================================================================
module uvs_sincos
    import uvs_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        phase,
    output logic signed [31:0] sin_q30,
    output logic signed [31:0] cos_q30
);

    localparam int NT = 2 + 3 * HORNER_STEPS;

    logic [30:0] a_reg    [0:NT-1];
    logic [31:0] a2_reg   [1:NT-1];
    logic [1:0]  quad_reg [0:NT];

    logic [31:0] yc_reg  [0:HORNER_STEPS-1];
    logic [31:0] ycd_reg [0:HORNER_STEPS-1];
    logic [31:0] qc_reg  [0:HORNER_STEPS-1];
    logic [30:0] tc_reg  [0:HORNER_STEPS-1];
    logic [31:0] ys_reg  [1:HORNER_STEPS-1];
    logic [31:0] ysd_reg [1:HORNER_STEPS-1];
    logic [31:0] qs_reg  [1:HORNER_STEPS-1];
    logic [30:0] ts_reg  [1:HORNER_STEPS-1];

    logic [31:0] sin_pr_reg;
    logic [31:0] cos_pr_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0]    <= 31'((62'(phase[29:0]) * 62'(HALF_PI_Q30)) >> 30);
            quad_reg[0] <= phase[31:30];
            a2_reg[1]   <= 32'((62'(a_reg[0]) * 62'(a_reg[0])) >> 30);
            for (int n = 1; n < NT; n++)
            begin
                a_reg[n] <= a_reg[n-1];
            end
            for (int n = 2; n < NT; n++)
            begin
                a2_reg[n] <= a2_reg[n-1];
            end
            for (int n = 1; n <= NT; n++)
            begin
                quad_reg[n] <= quad_reg[n-1];
            end
        end
    end

    for (genvar s = 0; s < HORNER_STEPS; s++)
    begin : g_step
        localparam int KC = 14 - 2 * s;
        localparam int DC = KC * (KC - 1);
        localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);
        logic [30:0] tc_in;

        if (s == 0)
        begin : g_first
            assign tc_in = ONE_Q30;
        end
        else
        begin : g_next
            assign tc_in = tc_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                yc_reg[s]  <= 32'((63'(a2_reg[1+3*s]) * 63'(tc_in)) >> 30);
                qc_reg[s]  <= 32'((64'(yc_reg[s]) * 64'(MC)) >> 32);
                ycd_reg[s] <= yc_reg[s];
                tc_reg[s]  <= horner_step(ycd_reg[s], qc_reg[s], 8'(DC));
            end
        end

        if (s >= 1)
        begin : g_sin
            localparam int KS = 15 - 2 * s;
            localparam int DS = KS * (KS - 1);
            localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
            logic [30:0] ts_in;

            if (s == 1)
            begin : g_first
                assign ts_in = ONE_Q30;
            end
            else
            begin : g_next
                assign ts_in = ts_reg[s-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ys_reg[s]  <= 32'((63'(a2_reg[1+3*s]) * 63'(ts_in)) >> 30);
                    qs_reg[s]  <= 32'((64'(ys_reg[s]) * 64'(MS)) >> 32);
                    ysd_reg[s] <= ys_reg[s];
                    ts_reg[s]  <= horner_step(ysd_reg[s], qs_reg[s], 8'(DS));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_pr_reg <= 32'((62'(a_reg[NT-1]) * 62'(ts_reg[HORNER_STEPS-1])) >> 30);
            cos_pr_reg <= 32'(tc_reg[HORNER_STEPS-1]);
            case (quad_reg[NT])
                2'd0:
                begin
                    sin_reg <= $signed(sin_pr_reg);
                    cos_reg <= $signed(cos_pr_reg);
                end
                2'd1:
                begin
                    sin_reg <= $signed(cos_pr_reg);
                    cos_reg <= -$signed(sin_pr_reg);
                end
                2'd2:
                begin
                    sin_reg <= -$signed(sin_pr_reg);
                    cos_reg <= -$signed(cos_pr_reg);
                end
                default:
                begin
                    sin_reg <= -$signed(cos_pr_reg);
                    cos_reg <= $signed(sin_pr_reg);
                end
            endcase
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule
